/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL.
// Each macro checks a property on the rising edge of clk_i, outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)

`endif

`endif

/* hdl/tle_pkg.sv */
`timescale 1ns / 1ps

package tle_pkg;

  // Default upper bound on the line length.
  localparam int unsigned LineMaxDefault = 255;

  // Reset value of the line length limit register.
  localparam logic [7:0] MaxLenReset = 8'd64;

  // Register map.
  localparam int unsigned RegAddrWidth = 3;
  localparam logic RegIdxMaxLen = 1'b0;

  // Console byte codes.
  localparam logic [7:0] KeyBackspace = 8'd8;
  localparam logic [7:0] KeyReturn    = 8'd13;
  localparam logic [7:0] KeyEscape    = 8'd27;
  localparam logic [7:0] KeyLastCtrl  = 8'd31;
  localparam logic [7:0] KeyDelete    = 8'd127;
  localparam logic [7:0] KeyBracket   = 8'h5B;
  localparam logic [7:0] KeyUpA       = 8'h41;
  localparam logic [7:0] KeyDownB     = 8'h42;
  localparam logic [7:0] ChrNewline   = 8'd10;
  localparam logic [7:0] ChrSpace     = 8'd32;
  localparam logic [7:0] ChrNone      = 8'd0;

  // Kind of result request.
  typedef enum logic [2:0] {
    EV_ECHO  = 3'd0,
    EV_STORE = 3'd1,
    EV_LINE  = 3'd2,
    EV_UP    = 3'd3,
    EV_DOWN  = 3'd4
  } ev_kind_e;

  // Progress through an escape sequence.
  typedef enum logic [1:0] {
    PH_NORMAL  = 2'd0,
    PH_ESC     = 2'd1,
    PH_BRACKET = 2'd2
  } esc_phase_e;

  // Position within the three-request backspace echo.
  typedef enum logic [1:0] {
    BS_FIRST  = 2'd0,
    BS_SPACE  = 2'd1,
    BS_LAST   = 2'd2
  } bs_step_e;

endpackage

/* hdl/terminal_line_editor.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Direction  Handshake                     Payload
// key       in         key_valid_i / key_ready_o     key_byte_i
// event     out        event_valid_o / event_ready_i event_kind_o, out_byte_o,
//                                                    position_o, last_of_run_o
// apb       in         psel, penable, pready         paddr, pwrite, pwdata, prdata
//
// A byte is registered in the input register on acceptance, then decoded into
// the result register once that register is free; requests come from it.
// A new byte is taken every cycle unless the result register is held, by
// event_ready_i low or by a backspace, which holds it for its three requests.
// Reset clears the line length, the escape progress and all valid flags, and
// loads the line length limit with 64. A stalled result register stalls the
// input register, which then drops key_ready_o.
module terminal_line_editor import tle_pkg::*; #(
  parameter int unsigned LINE_MAX = LineMaxDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Received console bytes
  input  logic                    key_valid_i,
  output logic                    key_ready_o,
  input  logic [7:0]              key_byte_i,
  // Result requests
  output logic                    event_valid_o,
  input  logic                    event_ready_i,
  output logic [2:0]              event_kind_o,
  output logic [7:0]              out_byte_o,
  output logic [7:0]              position_o,
  output logic                    last_of_run_o,
  // Configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [RegAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic [7:0] LineMaxC = LINE_MAX[7:0];

  // Configuration register.
  logic [7:0] max_len_q, max_len_d;
  logic       cfg_wr;
  logic [7:0] limit;

  // Input register.
  logic       in_vld_q, in_vld_d;
  logic [7:0] key_q, key_d;

  // Editing state.
  esc_phase_e phase_q, phase_d;
  logic [7:0] len_q, len_d;

  // Result register.
  logic       ob_vld_q, ob_vld_d;
  ev_kind_e   ob_kind_q, ob_kind_d;
  logic [7:0] ob_byte_q, ob_byte_d;
  logic [7:0] ob_pos_q, ob_pos_d;
  logic       ob_bs_q, ob_bs_d;
  bs_step_e   ob_step_q, ob_step_d;

  // Decode of the registered byte.
  logic       dec_produce;
  ev_kind_e   dec_kind;
  logic [7:0] dec_byte;
  logic [7:0] dec_pos;
  logic       dec_bs;
  esc_phase_e dec_phase;
  logic [7:0] dec_len;

  logic       out_last;
  logic       out_take;
  logic       advance;
  logic       commit;

  // Configuration writes and reads.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegIdxMaxLen);
  assign prdata = (paddr[2] == RegIdxMaxLen) ? {24'd0, max_len_q} : 32'd0;
  assign max_len_d = cfg_wr ? pwdata[7:0] : max_len_q;
  assign limit = (max_len_q < LineMaxC) ? max_len_q : LineMaxC;

  // Pipeline flow: the decode stage moves when the result register frees up.
  assign out_last = !ob_bs_q || (ob_step_q == BS_LAST);
  assign out_take = ob_vld_q && event_ready_i;
  assign advance  = !ob_vld_q || (event_ready_i && out_last);
  assign commit   = in_vld_q && advance;
  assign key_ready_o = !in_vld_q || advance;

  // Input register load.
  always_comb begin
    in_vld_d = in_vld_q;
    key_d    = key_q;
    if (key_valid_i && key_ready_o) begin
      in_vld_d = 1'b1;
      key_d    = key_byte_i;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  // Byte decode against the escape progress and the line length.
  always_comb begin
    dec_produce = 1'b0;
    dec_kind    = EV_ECHO;
    dec_byte    = key_q;
    dec_pos     = len_q;
    dec_bs      = 1'b0;
    dec_phase   = PH_NORMAL;
    dec_len     = len_q;
    case (phase_q)
      PH_ESC: begin
        dec_phase = (key_q == KeyBracket) ? PH_BRACKET : PH_NORMAL;
      end
      PH_BRACKET: begin
        dec_byte = ChrNone;
        if (key_q == KeyUpA) begin
          dec_produce = 1'b1;
          dec_kind    = EV_UP;
        end else if (key_q == KeyDownB) begin
          dec_produce = 1'b1;
          dec_kind    = EV_DOWN;
        end
      end
      default: begin
        if (key_q == KeyEscape) begin
          dec_phase = PH_ESC;
        end else if (key_q == KeyBackspace || key_q == KeyDelete) begin
          if (len_q != 8'd0) begin
            dec_produce = 1'b1;
            dec_bs      = 1'b1;
            dec_len     = len_q - 8'd1;
            dec_pos     = len_q - 8'd1;
            dec_byte    = KeyBackspace;
          end
        end else if (key_q == KeyReturn) begin
          dec_produce = 1'b1;
          dec_kind    = EV_LINE;
          dec_byte    = ChrNewline;
          dec_len     = 8'd0;
        end else if (key_q > KeyLastCtrl && !key_q[7] && len_q < limit) begin
          dec_produce = 1'b1;
          dec_kind    = EV_STORE;
          dec_len     = len_q + 8'd1;
        end
      end
    endcase
  end

  // State update once the byte leaves the decode stage.
  assign phase_d = commit ? dec_phase : phase_q;
  assign len_d   = commit ? dec_len : len_q;

  // Result register load and step through the backspace echo.
  always_comb begin
    ob_vld_d  = ob_vld_q;
    ob_kind_d = ob_kind_q;
    ob_byte_d = ob_byte_q;
    ob_pos_d  = ob_pos_q;
    ob_bs_d   = ob_bs_q;
    ob_step_d = ob_step_q;
    if (commit) begin
      ob_vld_d  = dec_produce;
      ob_kind_d = dec_kind;
      ob_byte_d = dec_byte;
      ob_pos_d  = dec_pos;
      ob_bs_d   = dec_bs;
      ob_step_d = BS_FIRST;
    end else if (out_take) begin
      if (out_last) begin
        ob_vld_d  = 1'b0;
        ob_bs_d   = 1'b0;
        ob_step_d = BS_FIRST;
      end else if (ob_step_q == BS_FIRST) begin
        ob_step_d = BS_SPACE;
      end else begin
        ob_step_d = BS_LAST;
      end
    end
  end

  // Result outputs.
  always_comb begin
    event_valid_o = ob_vld_q;
    event_kind_o  = ob_kind_q;
    position_o    = ob_pos_q;
    last_of_run_o = out_last;
    out_byte_o    = ob_byte_q;
    if (ob_bs_q && ob_step_q == BS_SPACE) begin
      out_byte_o = ChrSpace;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
      in_vld_q  <= 1'b0;
      phase_q   <= PH_NORMAL;
      len_q     <= 8'd0;
      ob_vld_q  <= 1'b0;
      ob_bs_q   <= 1'b0;
      ob_step_q <= BS_FIRST;
    end else begin
      max_len_q <= max_len_d;
      in_vld_q  <= in_vld_d;
      phase_q   <= phase_d;
      len_q     <= len_d;
      ob_vld_q  <= ob_vld_d;
      ob_bs_q   <= ob_bs_d;
      ob_step_q <= ob_step_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    ob_kind_q <= ob_kind_d;
    ob_byte_q <= ob_byte_d;
    ob_pos_q  <= ob_pos_d;
  end

  // Only a backspace echo ever steps past its first request.
  `ASSERT_CLK(a_step_only_bs, (ob_vld_q && !ob_bs_q) |-> (ob_step_q == BS_FIRST))
  // A byte in the decode stage is held while the result register is busy.
  `ASSERT_CLK(a_decode_holds, (in_vld_q && !advance) |=> (in_vld_q && $stable(key_q)))
  // The escape progress never reaches the unused code.
  `ASSERT_NEVER(a_phase_unused, phase_q == esc_phase_e'(2'd3))
  // Taking the final request with nothing decoded empties the result register.
  `ASSERT_CLK(a_last_empties, (out_take && out_last && !in_vld_q) |=> !ob_vld_q)

endmodule
